>>> rtl/resampling_audio_voice_defines.svh
// Assertion macros for the voice checker.
`ifndef RESAMPLING_AUDIO_VOICE_DEFINES_SVH
`define RESAMPLING_AUDIO_VOICE_DEFINES_SVH

// Checked only outside reset.
`define RAV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("voice assertion failed");

// Checked at every edge, reset included.
`define RAV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("voice assertion failed");

`endif

>>> rtl/rav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rav_pkg;

  localparam int unsigned POS_W    = 48;
  localparam int unsigned IDX_W    = 36;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned MIX_W    = 32;
  localparam int unsigned RATE_W   = 20;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned IN_DW    = 104;
  localparam int unsigned OUT_DW   = 72;

  // register indexes on the config port
  localparam logic [CFG_AW-1:0] REG_STEP_RATE     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_LEFT_GAIN     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RIGHT_GAIN    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LOOP_ENABLE   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_STREAM_LENGTH = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 3'd0,
    OP_RENDER = 3'd1,
    OP_PLAY   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_STOP   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    VS_STOPPED = 2'd0,
    VS_PLAYING = 2'd1,
    VS_PAUSED  = 2'd2
  } voice_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_MULT = 5'b00100,
    S_MIX  = 5'b01000,
    S_OUT  = 5'b10000
  } fsm_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic mul_en;
    logic mix_en;
    logic go;
  } lane_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/rav_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module rav_lane #(
  parameter int unsigned RING_DEPTH = 2048,
  parameter int unsigned FRAC_BITS  = 12,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  wire logic                              clk_i,
  input  wire rav_pkg::lane_ctrl_t               ctrl_i,
  input  wire logic [AW-1:0]                     wr_addr_i,
  input  wire logic [rav_pkg::SMP_W-1:0]         wr_data_i,
  input  wire logic [AW-1:0]                     rd_addr_a_i,
  input  wire logic [AW-1:0]                     rd_addr_b_i,
  input  wire logic [FRAC_BITS-1:0]              frac_i,
  input  wire logic [rav_pkg::MIX_W-1:0]         mix_i,
  input  wire logic [rav_pkg::GAIN_W-1:0]        gain_i,
  output logic      [rav_pkg::MIX_W-1:0]         out_o
);

  localparam int unsigned PW = 18 + FRAC_BITS;
  localparam int unsigned GW = rav_pkg::MIX_W + rav_pkg::GAIN_W + 1;

  logic [rav_pkg::SMP_W-1:0] ring_q [RING_DEPTH];
  logic [rav_pkg::SMP_W-1:0] a_q, b_q;
  logic [FRAC_BITS-1:0]      frac_q;
  logic signed [PW-1:0]      prod_d, prod_q, sh;
  logic signed [16:0]        diff;
  logic signed [17:0]        interp;
  logic [rav_pkg::MIX_W-1:0] sum_d, sum_q;
  logic signed [GW-1:0]      gprod;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      ring_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      a_q    <= ring_q[rd_addr_a_i];
      b_q    <= ring_q[rd_addr_b_i];
      frac_q <= frac_i;
    end
  end

  assign diff   = $signed({b_q[15], b_q}) - $signed({a_q[15], a_q});
  assign prod_d = diff * $signed({1'b0, frac_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // floor shift keeps the point between a and b, so 18 bits hold it
  assign sh     = prod_q >>> FRAC_BITS;
  assign interp = sh[17:0] + {{2{a_q[15]}}, a_q};
  assign sum_d  = mix_i + (ctrl_i.go ? {{14{interp[17]}}, interp} : '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mix_en) begin
      sum_q <= sum_d;
    end
  end

  assign gprod = $signed(sum_q) * $signed({1'b0, gain_i});
  assign out_o = gprod[FRAC_BITS+31:FRAC_BITS];

endmodule
`default_nettype wire

>>> rtl/resampling_audio_voice.sv
// The voice takes one item at a time; the sequencer steps evaluate, ring read
// and interpolation multiply, mix add, gain multiply in each lane, and loads
// the output register in the out state once that register is free.
// A finished item waits in the output register while the next item is taken.
// Reset (async, active low) clears control, position, indices and config to
// their reset values; ring contents stay undefined, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module resampling_audio_voice #(
  parameter int unsigned RING_DEPTH = 2048,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rav_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  wire logic [rav_pkg::CFG_DW-1:0]    cfg_data_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // sample_left, sample_right, restart, mix_left, mix_right, zero pad
  input  wire logic [rav_pkg::IN_DW-1:0]     s_axis_tdata_i,
  // operation
  input  wire logic [rav_pkg::OP_W-1:0]      s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // out_left, out_right, voice_state, refill_request, starved, rewind_request,
  // zero pad
  output logic      [rav_pkg::OUT_DW-1:0]    m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [rav_pkg::IDX_W-1:0] HALF = rav_pkg::IDX_W'(RING_DEPTH / 2);

  // config
  logic [rav_pkg::RATE_W-1:0] step_rate_q;
  logic [rav_pkg::GAIN_W-1:0] left_gain_q, right_gain_q;
  logic                       loop_en_q;
  logic [rav_pkg::LEN_W-1:0]  stream_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_rate_q  <= 20'd4096;
      left_gain_q  <= 16'd4096;
      right_gain_q <= 16'd4096;
      loop_en_q    <= 1'b0;
      stream_len_q <= 32'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        rav_pkg::REG_STEP_RATE:     step_rate_q  <= cfg_data_i[rav_pkg::RATE_W-1:0];
        rav_pkg::REG_LEFT_GAIN:     left_gain_q  <= cfg_data_i[rav_pkg::GAIN_W-1:0];
        rav_pkg::REG_RIGHT_GAIN:    right_gain_q <= cfg_data_i[rav_pkg::GAIN_W-1:0];
        rav_pkg::REG_LOOP_ENABLE:   loop_en_q    <= cfg_data_i[0];
        rav_pkg::REG_STREAM_LENGTH: stream_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched item
  rav_pkg::op_e              op_q;
  logic                      restart_q;
  logic [rav_pkg::SMP_W-1:0] sl_q, sr_q;
  logic [rav_pkg::MIX_W-1:0] ml_q, mr_q;

  rav_pkg::fsm_e state_q, state_d;
  logic          accept;
  logic          load_out;

  assign s_axis_tready_o = (state_q == rav_pkg::S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load_out        = (state_q == rav_pkg::S_OUT) &&
                           (!m_axis_tvalid_o || m_axis_tready_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= rav_pkg::op_e'(s_axis_tuser_i);
      sl_q      <= s_axis_tdata_i[15:0];
      sr_q      <= s_axis_tdata_i[31:16];
      restart_q <= s_axis_tdata_i[32];
      ml_q      <= s_axis_tdata_i[64:33];
      mr_q      <= s_axis_tdata_i[96:65];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rav_pkg::S_IDLE: if (accept) state_d = rav_pkg::S_EVAL;
      rav_pkg::S_EVAL: state_d = rav_pkg::S_MULT;
      rav_pkg::S_MULT: state_d = rav_pkg::S_MIX;
      rav_pkg::S_MIX:  state_d = rav_pkg::S_OUT;
      rav_pkg::S_OUT:  if (load_out) state_d = rav_pkg::S_IDLE;
      default:         state_d = rav_pkg::S_IDLE;
    endcase
  end

  // voice state
  logic [rav_pkg::POS_W-1:0] pos_q, pos_d;
  logic [rav_pkg::IDX_W-1:0] end_q, end_d;
  logic [rav_pkg::IDX_W-1:0] wend_q, wend_d;
  rav_pkg::voice_e           vs_q, vs_d;
  logic                      go_q, go_d;
  logic                      rew_q, rew_d;
  logic                      wr_en, rd_en;
  logic [rav_pkg::IDX_W-1:0] idx, idx_nx;

  assign idx    = rav_pkg::IDX_W'(pos_q >> FRAC_BITS);
  assign idx_nx = idx + 36'd1;

  always_comb begin
    pos_d  = pos_q;
    end_d  = end_q;
    wend_d = wend_q;
    vs_d   = vs_q;
    go_d   = go_q;
    rew_d  = rew_q;
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    if (state_q == rav_pkg::S_EVAL) begin
      go_d  = 1'b0;
      rew_d = 1'b0;
      unique case (op_q)
        rav_pkg::OP_WRITE: begin
          wr_en  = 1'b1;
          wend_d = wend_q + 36'd1;
        end
        rav_pkg::OP_RENDER: begin
          rd_en = 1'b1;
          if (vs_q == rav_pkg::VS_PLAYING) begin
            go_d = 1'b1;
            if (idx >= end_q) begin
              if (!loop_en_q) begin
                vs_d = rav_pkg::VS_STOPPED;
                go_d = 1'b0;
              end else begin
                end_d = idx + {4'd0, stream_len_q};
              end
            end
            if (go_d) begin
              pos_d = pos_q + {28'd0, step_rate_q};
            end
          end
        end
        rav_pkg::OP_PLAY: begin
          if (restart_q || vs_q == rav_pkg::VS_STOPPED) begin
            pos_d  = '0;
            wend_d = '0;
            end_d  = {4'd0, stream_len_q};
            rew_d  = 1'b1;
          end
          vs_d = rav_pkg::VS_PLAYING;
        end
        rav_pkg::OP_PAUSE: begin
          if (vs_q == rav_pkg::VS_PLAYING) begin
            vs_d = rav_pkg::VS_PAUSED;
          end else if (vs_q == rav_pkg::VS_PAUSED) begin
            vs_d = rav_pkg::VS_PLAYING;
          end
        end
        rav_pkg::OP_STOP: vs_d = rav_pkg::VS_STOPPED;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rav_pkg::S_IDLE;
      pos_q   <= '0;
      end_q   <= '0;
      wend_q  <= '0;
      vs_q    <= rav_pkg::VS_STOPPED;
      go_q    <= 1'b0;
      rew_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      end_q   <= end_d;
      wend_q  <= wend_d;
      vs_q    <= vs_d;
      go_q    <= go_d;
      rew_q   <= rew_d;
    end
  end

  // lanes
  rav_pkg::lane_ctrl_t       ctrl;
  logic [rav_pkg::MIX_W-1:0] lane_l, lane_r;

  assign ctrl.wr_en  = wr_en;
  assign ctrl.rd_en  = rd_en;
  assign ctrl.mul_en = (state_q == rav_pkg::S_MULT);
  assign ctrl.mix_en = (state_q == rav_pkg::S_MIX);
  assign ctrl.go     = go_q;

  rav_lane #(.RING_DEPTH(RING_DEPTH), .FRAC_BITS(FRAC_BITS)) u_lane_l (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .wr_addr_i   (wend_q[AW-1:0]),
    .wr_data_i   (sl_q),
    .rd_addr_a_i (idx[AW-1:0]),
    .rd_addr_b_i (idx_nx[AW-1:0]),
    .frac_i      (pos_q[FRAC_BITS-1:0]),
    .mix_i       (ml_q),
    .gain_i      (left_gain_q),
    .out_o       (lane_l)
  );

  rav_lane #(.RING_DEPTH(RING_DEPTH), .FRAC_BITS(FRAC_BITS)) u_lane_r (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .wr_addr_i   (wend_q[AW-1:0]),
    .wr_data_i   (sr_q),
    .rd_addr_a_i (idx[AW-1:0]),
    .rd_addr_b_i (idx_nx[AW-1:0]),
    .frac_i      (pos_q[FRAC_BITS-1:0]),
    .mix_i       (mr_q),
    .gain_i      (right_gain_q),
    .out_o       (lane_r)
  );

  // merge: lane results plus status after the item
  logic [rav_pkg::IDX_W-1:0]  ahead;
  logic                       refill, starved;
  logic                       is_render;
  logic [rav_pkg::OUT_DW-1:0] out_d;
  logic                       out_valid_q;

  assign ahead     = (wend_q > idx) ? (wend_q - idx) : '0;
  assign refill    = (ahead < HALF);
  assign starved   = (idx_nx >= wend_q) || (idx == '1);
  assign is_render = (op_q == rav_pkg::OP_RENDER);
  assign out_d     = {3'd0, rew_q, starved, refill, vs_q,
                      (is_render ? lane_r : '0), (is_render ? lane_l : '0)};

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_axis_tdata_o <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/rav_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "resampling_audio_voice_defines.svh"
module rav_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid_i,
  input wire logic                       s_axis_tready_o,
  input wire logic                       m_axis_tvalid_o,
  input wire logic                       m_axis_tready_i,
  input wire logic [rav_pkg::OUT_DW-1:0] m_axis_tdata_o
);

  // a held result stays offered
  `RAV_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
  // one item at a time: the sequencer is busy right after an accept
  `RAV_ASSERT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
  // a rewind only comes from a play, which leaves the voice playing
  `RAV_ASSERT(a_rewind_playing, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[68] |-> m_axis_tdata_o[65:64] == rav_pkg::VS_PLAYING)
  // no result is offered right after reset has been seen
  `RAV_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind resampling_audio_voice rav_checker u_rav_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
